/* rtl/graph_adjacency_walk_engine_unit_defines.svh */
// Assertion macros for the graph walk engine.
`ifndef GRAPH_ADJACENCY_WALK_ENGINE_UNIT_DEFINES_SVH
`define GRAPH_ADJACENCY_WALK_ENGINE_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
`define GAW_ASSERT_IMP(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error("assertion failed: %m");
`define GAW_ASSERT_NXT(label, clk, rst_n, a, c) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error("assertion failed: %m");
`else
`define GAW_ASSERT_IMP(label, clk, rst_n, a, c)
`define GAW_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

/* rtl/gawe_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gawe_pkg
// Shared opcodes and status codes of the graph walk engine.
// ----------------------------------------------------------------------------
package gawe_pkg;
  typedef enum logic [1:0] {
    OP_ADD = 2'd0,
    OP_REMOVE = 2'd1,
    OP_BFS = 2'd2,
    OP_DFS = 2'd3
  } op_t;
  typedef enum logic [1:0] {
    ST_OK = 2'd0,
    ST_FULL = 2'd1,
    ST_RANGE = 2'd2
  } status_t;
  localparam int RESULT_LIMIT = 16;
endpackage

/* rtl/gawe_ram.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gawe_ram
// Single write, single read synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module gawe_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 4
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

/* rtl/graph_adjacency_walk_engine_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// graph_adjacency_walk_engine_unit
// Adjacency lists in a memory, add/remove edges, breadth and depth walks.
// ----------------------------------------------------------------------------
// channel | dir | payload
// in_     | in  | tdata: op, vertex_a, vertex_b
// out_    | out | tdata: visited_vertex, vertex_valid, status, edge_count,
//         |     |   graph_empty; tlast: last
// cfg_    | in  | vertex_count
// An add writes both adjacency lists in turn; a rejected update writes nothing.
// A remove scans both lists, shifting the entries after the match down by one.
// A walk first searches for the start vertex, then pops the work list, pushes
// the neighbors of each newly visited vertex and emits one result beat per
// visited vertex; the single read ports serialize these steps.
// Reset clears lengths and edge count and sets vertex count to 16; no clearing pass.
// A stalled output beat holds the engine at that point.
// ----------------------------------------------------------------------------
module graph_adjacency_walk_engine_unit #(
  parameter int MAX_VERTICES = 16,
  parameter int MAX_DEGREE = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [4:0]  cfg_wdata,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // op[1:0], vertex_a[5:2], vertex_b[9:6]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // visited_vertex, vertex_valid, status,
                                  // edge_count, graph_empty
  output logic        out_tlast
);
  import gawe_pkg::*;
  `include "graph_adjacency_walk_engine_unit_defines.svh"

  localparam int VW = $clog2(MAX_VERTICES);
  localparam int DW = (MAX_DEGREE > 1) ? $clog2(MAX_DEGREE) : 1;
  localparam int LW = $clog2(MAX_DEGREE + 1);
  localparam int AW = VW + DW;
  localparam int WD = MAX_VERTICES * MAX_DEGREE + 1;
  localparam int WW = $clog2(WD + 1);
  localparam int WAW = $clog2(WD);

  typedef enum logic [3:0] {
    S_IDLE, S_ADD1, S_ADD2, S_RSET, S_RRD, S_RCHK, S_RSHF, S_WFIND,
    S_POP, S_VIS, S_PRD, S_PWR, S_OUT
  } st_t;

  st_t st_r;
  logic [4:0] vcnt_r;
  logic [LW-1:0] len_r [MAX_VERTICES];
  logic [7:0] edges_r;
  logic [MAX_VERTICES-1:0] vis_r;
  logic [1:0] op_r;
  logic [3:0] a_r, b_r;
  logic [VW-1:0] lst_r;
  logic [3:0] val_r;
  logic pass_r, found_r;
  logic [LW-1:0] idx_r;
  logic [WW-1:0] head_r, tail_r;
  logic [4:0] cnt_r;
  logic [VW-1:0] cur_r;
  logic have_r;
  logic [3:0] ov_r;
  logic ovl_r, olast_r;
  logic [1:0] ost_r;
  logic fin_r;

  logic am_we; logic [AW-1:0] am_wa, am_ra; logic [3:0] am_wd, am_rd;
  logic wl_we; logic [WAW-1:0] wl_wa, wl_ra; logic [3:0] wl_wd, wl_rd;

  gawe_ram #(.DEPTH(MAX_VERTICES*MAX_DEGREE), .WIDTH(4)) u_adj (
    .clk(clk), .we(am_we), .waddr(am_wa), .wdata(am_wd), .raddr(am_ra), .rdata(am_rd));
  gawe_ram #(.DEPTH(WD), .WIDTH(4)) u_work (
    .clk(clk), .we(wl_we), .waddr(wl_wa), .wdata(wl_wd), .raddr(wl_ra), .rdata(wl_rd));

  logic [4:0] nact;
  assign nact = (32'(vcnt_r) > MAX_VERTICES) ? 5'(MAX_VERTICES) : vcnt_r;

  function automatic logic [AW-1:0] aaddr(input logic [VW-1:0] v, input logic [LW-1:0] i);
    return AW'((32'(v) * MAX_DEGREE) + 32'(i));
  endfunction

  assign in_tready = (st_r == S_IDLE);
  assign out_tvalid = (st_r == S_OUT);
  assign out_tlast = olast_r;
  assign out_tdata = {(edges_r == 8'd0), edges_r, ost_r, ovl_r, ov_r};

  logic [VW-1:0] a_v, b_v;
  assign a_v = VW'(a_r);
  assign b_v = VW'(b_r);

  // combinational memory controls
  always_comb begin
    am_we = 1'b0; am_wa = '0; am_wd = '0; am_ra = aaddr(lst_r, idx_r);
    wl_we = 1'b0; wl_wa = WAW'(tail_r); wl_wd = am_rd; wl_ra = WAW'(head_r);
    unique case (st_r)
      S_ADD1: begin am_we = 1'b1; am_wa = aaddr(a_v, len_r[a_v]); am_wd = b_r; end
      S_ADD2: begin am_we = 1'b1; am_wa = aaddr(b_v, len_r[b_v]); am_wd = a_r; end
      S_RCHK: am_ra = aaddr(lst_r, idx_r - LW'(1));
      S_RSHF: begin am_we = 1'b1; am_wa = aaddr(lst_r, idx_r - LW'(2)); am_wd = am_rd; end
      S_WFIND: begin wl_we = 1'b1; wl_wd = 4'(cur_r); end
      S_POP: wl_ra = (op_r == OP_DFS) ? WAW'(tail_r - WW'(1)) : WAW'(head_r);
      S_PWR: wl_we = (tail_r < WW'(WD));
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      vcnt_r <= 5'd16;
      edges_r <= '0;
      for (int i = 0; i < MAX_VERTICES; i++) len_r[i] <= '0;
      olast_r <= 1'b0;
      fin_r <= 1'b0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      if (cfg_we) vcnt_r <= cfg_wdata;
      unique case (st_r)
        S_IDLE: if (in_tvalid) begin
          op_r <= in_tdata[1:0]; a_r <= in_tdata[5:2]; b_r <= in_tdata[9:6];
          ov_r <= '0; ovl_r <= 1'b0; olast_r <= 1'b1;
          if (in_tdata[1]) begin
            ost_r <= ST_OK;
            vis_r <= '0; cur_r <= '0; found_r <= 1'b0; head_r <= '0; tail_r <= '0;
            cnt_r <= '0; have_r <= 1'b0; st_r <= S_WFIND;
          end else if (5'(in_tdata[5:2]) >= nact || 5'(in_tdata[9:6]) >= nact) begin
            ost_r <= ST_RANGE; st_r <= S_OUT;
          end else if (in_tdata[1:0] == OP_ADD) begin
            if ((in_tdata[5:2] == in_tdata[9:6]) ?
                (32'(len_r[VW'(in_tdata[5:2])]) + 2 > MAX_DEGREE) :
                (32'(len_r[VW'(in_tdata[5:2])]) >= MAX_DEGREE ||
                 32'(len_r[VW'(in_tdata[9:6])]) >= MAX_DEGREE)) begin
              ost_r <= ST_FULL; st_r <= S_OUT;
            end else begin
              ost_r <= ST_OK; st_r <= S_ADD1;
            end
          end else begin
            ost_r <= ST_OK; pass_r <= 1'b0; st_r <= S_RSET;
          end
        end
        S_ADD1: begin len_r[a_v] <= len_r[a_v] + LW'(1); st_r <= S_ADD2; end
        S_ADD2: begin
          len_r[b_v] <= len_r[b_v] + LW'(1);
          if (edges_r != 8'd255) edges_r <= edges_r + 8'd1;
          st_r <= S_OUT;
        end
        S_RSET: begin
          lst_r <= pass_r ? b_v : a_v; val_r <= pass_r ? a_r : b_r;
          idx_r <= '0; found_r <= 1'b0; st_r <= S_RRD;
        end
        S_RRD: begin
          if (idx_r >= len_r[lst_r]) begin
            if (found_r) len_r[lst_r] <= len_r[lst_r] - LW'(1);
            if (pass_r) begin
              if (edges_r != 8'd0) edges_r <= edges_r - 8'd1;
              st_r <= S_OUT;
            end else begin pass_r <= 1'b1; st_r <= S_RSET; end
          end else begin idx_r <= idx_r + LW'(1); st_r <= S_RCHK; end
        end
        S_RCHK: begin
          // am_rd holds entry idx_r-1
          if (found_r) st_r <= S_RSHF;
          else begin
            if (am_rd == val_r) found_r <= 1'b1;
            st_r <= S_RRD;
          end
        end
        S_RSHF: st_r <= S_RRD;
        S_WFIND: begin
          if (5'(cur_r) < nact && len_r[cur_r] != '0) begin
            tail_r <= WW'(1); found_r <= 1'b1; st_r <= S_POP;
          end else if (32'(cur_r) == MAX_VERTICES - 1 || 5'(cur_r) >= nact) begin
            st_r <= S_OUT;
          end else cur_r <= cur_r + VW'(1);
        end
        S_POP: begin
          if (head_r >= tail_r || cnt_r == 5'(RESULT_LIMIT)) begin
            ov_r <= 4'(cur_r); ovl_r <= 1'b1; olast_r <= 1'b1; fin_r <= 1'b1;
            st_r <= S_OUT;
          end else begin
            if (op_r == OP_DFS) tail_r <= tail_r - WW'(1); else head_r <= head_r + WW'(1);
            st_r <= S_VIS;
          end
        end
        S_VIS: begin
          if (32'(wl_rd) >= MAX_VERTICES || vis_r[VW'(wl_rd)]) st_r <= S_POP;
          else begin
            if (have_r) begin
              ov_r <= 4'(cur_r); ovl_r <= 1'b1; olast_r <= 1'b0; fin_r <= 1'b0;
              st_r <= S_OUT;
            end else st_r <= S_PRD;
            have_r <= 1'b1;
            vis_r[VW'(wl_rd)] <= 1'b1;
            cur_r <= VW'(wl_rd); lst_r <= VW'(wl_rd); idx_r <= '0;
            cnt_r <= cnt_r + 5'd1;
          end
        end
        S_PRD: begin
          if (idx_r >= len_r[lst_r]) st_r <= S_POP;
          else begin idx_r <= idx_r + LW'(1); st_r <= S_PWR; end
        end
        S_PWR: begin
          if (tail_r < WW'(WD)) tail_r <= tail_r + WW'(1);
          st_r <= S_PRD;
        end
        S_OUT: if (out_tready) begin
          if (op_r[1] && found_r && !fin_r) st_r <= S_PRD;
          else begin st_r <= S_IDLE; fin_r <= 1'b0; end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `GAW_ASSERT_IMP(a_ready_idle, clk, rst_n, in_tready, !out_tvalid)
  `GAW_ASSERT_NXT(a_upd_one, clk, rst_n, in_tvalid && in_tready && !in_tdata[1], !in_tready)
  `GAW_ASSERT_IMP(a_tail_bound, clk, rst_n, 1'b1, 32'(tail_r) <= WD)
endmodule

/* sim/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Drives edge updates and breadth/depth walks into the graph walk engine,
// predicts every result beat from a local copy of the adjacency lists and
// checks each beat field by field, under random idling on both sides.
// ----------------------------------------------------------------------------
import gawe_pkg::*;

typedef struct {
  logic [3:0] vertex;
  logic       vertex_valid;
  logic       last;
  logic [1:0] status;
  logic [7:0] edge_count;
  logic       graph_empty;
} walk_beat_t;

class graph_scoreboard;
  logic [4:0] vertex_count;
  logic [3:0] adj [16][16];
  int unsigned adj_len [16];
  int unsigned edges;
  walk_beat_t pending_beats[$];
  int errors;

  function new();
    vertex_count = 16;
    edges = 0;
    errors = 0;
    foreach (adj_len[i]) adj_len[i] = 0;
  endfunction

  function int unsigned active_count();
    return (vertex_count > 16) ? 16 : vertex_count;
  endfunction

  function void push_beat(logic [3:0] v, logic vld, logic lst, status_t st);
    walk_beat_t b;
    b.vertex = v;
    b.vertex_valid = vld;
    b.last = lst;
    b.status = st;
    b.edge_count = edges[7:0];
    b.graph_empty = (edges == 0);
    pending_beats.insert(pending_beats.size(), b);
  endfunction

  function void drop_first(int unsigned lst, logic [3:0] val);
    for (int unsigned i = 0; i < adj_len[lst]; i++) begin
      if (adj[lst][i] == val) begin
        for (int unsigned k = i; k + 1 < adj_len[lst]; k++) adj[lst][k] = adj[lst][k + 1];
        adj_len[lst]--;
        return;
      end
    end
  endfunction

  function void predict_walk(bit depth_first);
    logic [3:0] work [257];
    logic [3:0] order [16];
    bit seen [16];
    int unsigned head, tail, n, cnt;
    logic [3:0] v;
    bit found;
    n = active_count();
    head = 0;
    tail = 0;
    cnt = 0;
    found = 0;
    foreach (seen[i]) seen[i] = 0;
    for (int unsigned i = 0; i < n; i++) begin
      if (adj_len[i] != 0) begin
        work[tail++] = i[3:0];
        found = 1;
        break;
      end
    end
    if (!found) begin
      push_beat(4'd0, 1'b0, 1'b1, ST_OK);
      return;
    end
    while (head < tail && cnt < RESULT_LIMIT) begin
      if (depth_first) begin
        tail--;
        v = work[tail];
      end else begin
        v = work[head++];
      end
      if (seen[v]) continue;
      seen[v] = 1;
      order[cnt++] = v;
      for (int unsigned j = 0; j < adj_len[v] && tail < 257; j++) work[tail++] = adj[v][j];
    end
    for (int unsigned k = 0; k < cnt; k++) push_beat(order[k], 1'b1, k == cnt - 1, ST_OK);
  endfunction

  function void note_item(op_t op, logic [3:0] a, logic [3:0] b);
    int unsigned n;
    bit fits;
    n = active_count();
    if (op == OP_BFS || op == OP_DFS) begin
      predict_walk(op == OP_DFS);
      return;
    end
    if (a >= n || b >= n) begin
      push_beat(4'd0, 1'b0, 1'b1, ST_RANGE);
      return;
    end
    if (op == OP_ADD) begin
      fits = (a == b) ? (adj_len[a] + 2 <= 16) : (adj_len[a] < 16 && adj_len[b] < 16);
      if (!fits) begin
        push_beat(4'd0, 1'b0, 1'b1, ST_FULL);
        return;
      end
      adj[a][adj_len[a]++] = b;
      adj[b][adj_len[b]++] = a;
      if (edges < 255) edges++;
    end else begin
      drop_first(a, b);
      drop_first(b, a);
      if (edges > 0) edges--;
    end
    push_beat(4'd0, 1'b0, 1'b1, ST_OK);
  endfunction

  function void check_beat(logic [15:0] data, logic tlast);
    walk_beat_t e;
    if (pending_beats.size() == 0) begin
      $error("unexpected result beat %h", data);
      errors++;
      return;
    end
    e = pending_beats.pop_front();
    if (data[3:0] !== e.vertex) begin
      $error("visited_vertex exp %0d got %0d", e.vertex, data[3:0]);
      errors++;
    end
    if (data[4] !== e.vertex_valid) begin
      $error("vertex_valid exp %0d got %0d", e.vertex_valid, data[4]);
      errors++;
    end
    if (tlast !== e.last) begin
      $error("last exp %0d got %0d", e.last, tlast);
      errors++;
    end
    if (data[6:5] !== e.status) begin
      $error("status exp %0d got %0d", e.status, data[6:5]);
      errors++;
    end
    if (data[14:7] !== e.edge_count) begin
      $error("edge_count exp %0d got %0d", e.edge_count, data[14:7]);
      errors++;
    end
    if (data[15] !== e.graph_empty) begin
      $error("graph_empty exp %0d got %0d", e.graph_empty, data[15]);
      errors++;
    end
  endfunction
endclass

module tb;
  logic        clk;
  logic        rst_n;
  logic        cfg_we;
  logic [4:0]  cfg_wdata;
  logic        in_tvalid;
  logic        in_tready;
  logic [15:0] in_tdata;
  logic        out_tvalid;
  logic        out_tready;
  logic [15:0] out_tdata;
  logic        out_tlast;

  graph_scoreboard sb;
  int  items_taken;
  bit  quiet;
  bit  long_hold_done;
  int  hold_cycles;

  graph_adjacency_walk_engine_unit dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_tvalid(in_tvalid), .in_tready(in_tready), .in_tdata(in_tdata),
    .out_tvalid(out_tvalid), .out_tready(out_tready), .out_tdata(out_tdata),
    .out_tlast(out_tlast)
  );

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  initial begin
    #20000000;
    $display("tb: FAIL");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_beat(out_tdata, out_tlast);
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b1;
      hold_cycles <= 0;
    end else if (hold_cycles > 0) begin
      hold_cycles <= hold_cycles - 1;
      out_tready <= 1'b0;
    end else if (!long_hold_done && items_taken == 20) begin
      long_hold_done <= 1'b1;
      hold_cycles <= 400;
      out_tready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 9) == 0) begin
      hold_cycles <= $urandom_range(0, 6);
      out_tready <= 1'b0;
    end else begin
      out_tready <= 1'b1;
    end
  end

  task automatic send_item(op_t op, logic [3:0] a, logic [3:0] b);
    int gap;
    in_tvalid <= 1'b1;
    in_tdata <= {6'd0, b, a, op};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_item(op, a, b);
    items_taken++;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 7);
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.pending_beats.size() != 0) @(posedge clk);
  endtask

  task automatic set_vertex_count(logic [4:0] value);
    drain();
    repeat (60) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.vertex_count = value;
  endtask

  task automatic random_items(int count);
    int unsigned lim;
    int unsigned pick;
    logic [3:0] a;
    logic [3:0] b;
    op_t op;
    for (int i = 0; i < count; i++) begin
      lim = sb.active_count();
      if (lim == 0 || $urandom_range(0, 9) == 0) begin
        a = 4'($urandom_range(0, 15));
        b = 4'($urandom_range(0, 15));
      end else begin
        a = 4'($urandom_range(0, lim - 1));
        b = 4'($urandom_range(0, lim - 1));
      end
      pick = $urandom_range(0, 99);
      op = (pick < 45) ? OP_ADD : (pick < 65) ? OP_REMOVE : (pick < 83) ? OP_BFS : OP_DFS;
      if (i == count / 2 && count > 20) drain();
      send_item(op, a, b);
    end
  endtask

  initial begin
    sb = new();
    items_taken = 0;
    quiet = 0;
    long_hold_done = 0;
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = 5'd0;
    in_tvalid = 1'b0;
    in_tdata = 16'd0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_item(OP_BFS, 4'd0, 4'd0);
    send_item(OP_DFS, 4'd15, 4'd15);
    send_item(OP_REMOVE, 4'd3, 4'd4);
    send_item(OP_ADD, 4'd15, 4'd0);
    send_item(OP_ADD, 4'd7, 4'd7);
    send_item(OP_ADD, 4'd7, 4'd2);
    send_item(OP_ADD, 4'd2, 4'd9);
    send_item(OP_BFS, 4'd0, 4'd0);
    send_item(OP_DFS, 4'd0, 4'd0);
    send_item(OP_REMOVE, 4'd9, 4'd2);
    send_item(OP_REMOVE, 4'd9, 4'd2);
    for (int i = 0; i < 16; i++) send_item(OP_ADD, 4'd1, 4'd3);
    send_item(OP_ADD, 4'd1, 4'd3);
    send_item(OP_ADD, 4'd3, 4'd3);
    send_item(OP_BFS, 4'd0, 4'd0);

    set_vertex_count(5'd0);
    send_item(OP_ADD, 4'd0, 4'd0);
    send_item(OP_BFS, 4'd0, 4'd0);
    send_item(OP_DFS, 4'd0, 4'd0);
    set_vertex_count(5'd31);
    random_items(30);
    set_vertex_count(5'd1);
    for (int i = 0; i < 8; i++) send_item(OP_ADD, 4'd0, 4'd0);
    send_item(OP_ADD, 4'd0, 4'd1);
    send_item(OP_DFS, 4'd0, 4'd0);
    set_vertex_count(5'd5);
    random_items(40);
    set_vertex_count(5'd16);
    random_items(25);
    quiet = 1;
    random_items(25);

    drain();
    repeat (200) @(posedge clk);
    if (sb.errors == 0 && sb.pending_beats.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
